>>> design/pgf_pkg.sv
`default_nettype none
package pgf_pkg;

    // Default number of fraction bits of the Q formats.
    localparam int FRAC_BITS_DEF = 12;

    // Field widths.
    localparam int POS_W    = 32;
    localparam int DIFF_W   = 33;
    localparam int MASS_W   = 32;
    localparam int RAD_W    = 31;
    localparam int RSUM_W   = 32;
    localparam int GC_W     = 16;
    localparam int FORCE_W  = 48;

    // Datapath widths.
    localparam int S_W        = 2 * DIFF_W;
    localparam int RR_W       = 2 * RSUM_W;
    localparam int ROOT_W     = 34;
    localparam int SQ_OP_W    = 2 * ROOT_W;
    localparam int SQ_RW      = ROOT_W + 4;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int GM_W       = GC_W + MASS_W;
    localparam int GM_SPLIT   = GM_W / 2;
    localparam int NP_W       = GM_SPLIT + DIFF_W;
    localparam int PROD_W     = GM_W + DIFF_W;
    localparam int HUND_W     = 7;
    localparam int D2_W       = 2 * ROOT_W;
    localparam int D100_W     = ROOT_W + HUND_W;
    localparam int DPART_W    = ROOT_W + D100_W;
    localparam int DSUM_W     = DPART_W + ROOT_W;
    localparam int DEN_W      = 105;

    // Quotient bits kept by the divider; larger quotients only raise overflow.
    localparam int QB      = FORCE_W + 1;
    localparam int DIV_LAT = QB + 1;

    localparam logic [HUND_W-1:0] HUNDRED = 7'd100;

    typedef struct packed {
        logic              coin;
        logic              negx;
        logic              negy;
        logic              coll;
        logic [DIFF_W-1:0] adx;
        logic [DIFF_W-1:0] ady;
        logic [GM_W-1:0]   gm;
    } t_side1;

    typedef struct packed {
        logic coin;
        logic negx;
        logic negy;
        logic coll;
    } t_side2;

endpackage
`default_nettype wire

>>> design/pgf_sqrt_cell.sv
`default_nettype none
module pgf_sqrt_cell import pgf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic [SQ_RW-1:0]   i_rem,
    input  wire logic [ROOT_W-1:0]  i_root,
    input  wire logic [SQ_OP_W-1:0] i_op,
    output logic      [SQ_RW-1:0]   o_rem,
    output logic      [ROOT_W-1:0]  o_root,
    output logic      [SQ_OP_W-1:0] o_op
);

    logic [SQ_RW-1:0]   n_cur;
    logic [SQ_RW-1:0]   n_trial;
    logic [SQ_RW-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [SQ_OP_W-1:0] r_op;

    // Bring down the next two bits of the operand and try a one in this place.
    assign n_cur   = {i_rem[SQ_RW-3:0], i_op[SQ_OP_W-1 -: 2]};
    assign n_trial = SQ_RW'({i_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (n_cur >= n_trial) begin
            r_rem  <= n_cur - n_trial;
            r_root <= {i_root[ROOT_W-2:0], 1'b1};
        end else begin
            r_rem  <= n_cur;
            r_root <= {i_root[ROOT_W-2:0], 1'b0};
        end
        r_op <= {i_op[SQ_OP_W-3:0], 2'b00};
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_op   = r_op;

endmodule
`default_nettype wire

>>> design/pgf_div_cell.sv
`default_nettype none
module pgf_div_cell import pgf_pkg::*; #(
    parameter int CW = DEN_W,
    parameter int K  = 0
) (
    input  wire logic             i_clk,
    input  wire logic [CW-1:0]    i_rem,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [QB-1:0]    i_q,
    input  wire logic             i_ovf,
    output logic      [CW-1:0]    o_rem,
    output logic      [DEN_W-1:0] o_den,
    output logic      [QB-1:0]    o_q,
    output logic                  o_ovf
);

    logic          n_take;
    logic [CW-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QB-1:0] r_q;
    logic          r_ovf;

    // Restoring step for quotient bit K.
    assign n_take = (i_rem >> K) >= CW'(i_den);

    always_ff @(posedge i_clk) begin
        r_rem <= n_take ? (i_rem - (CW'(i_den) << K)) : i_rem;
        r_den <= i_den;
        r_q   <= {i_q[QB-2:0], n_take};
        r_ovf <= i_ovf;
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;
    assign o_ovf = r_ovf;

endmodule
`default_nettype wire

>>> design/pgf_div.sv
`default_nettype none
module pgf_div import pgf_pkg::*; #(
    parameter int CW = DEN_W
) (
    input  wire logic             i_clk,
    input  wire logic [CW-1:0]    i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [QB-1:0]    o_q,
    output logic                  o_ovf
);

    logic [CW-1:0]    w_rem [QB+1];
    logic [DEN_W-1:0] w_den [QB+1];
    logic [QB-1:0]    w_q   [QB+1];
    logic             w_ovf [QB+1];

    logic [CW-1:0]    r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_ovf;

    // A quotient that does not fit in QB bits is flagged up front.
    always_ff @(posedge i_clk) begin
        r_rem <= i_num;
        r_den <= i_den;
        r_ovf <= (i_num >> QB) >= CW'(i_den);
    end

    assign w_rem[0] = r_rem;
    assign w_den[0] = r_den;
    assign w_q[0]   = '0;
    assign w_ovf[0] = r_ovf;

    for (genvar i = 0; i < QB; i++) begin : g_cell
        pgf_div_cell #(
            .CW (CW),
            .K  (QB - 1 - i)
        ) u_cell (
            .i_clk (i_clk),
            .i_rem (w_rem[i]),
            .i_den (w_den[i]),
            .i_q   (w_q[i]),
            .i_ovf (w_ovf[i]),
            .o_rem (w_rem[i+1]),
            .o_den (w_den[i+1]),
            .o_q   (w_q[i+1]),
            .o_ovf (w_ovf[i+1])
        );
    end

    assign o_q   = w_q[QB];
    assign o_ovf = w_ovf[QB];

endmodule
`default_nettype wire

>>> design/pair_gravity_force_unit.sv
`default_nettype none
// Pairwise gravity force unit. Each item gives the positions of bodies A and B, the mass
// of B and both radii in signed or unsigned fixed point with FRAC_BITS fraction bits, and
// yields one result: the pull of B on A as x and y components (Q36.12, clipped to the
// 48-bit range with o_saturated set), a collision flag for a distance below the radii sum,
// and a coincidence flag for equal positions, in which case both forces are zero. The unit
// is fully pipelined and takes a new item in every clock cycle; o_busy is high only while
// reset is applied and until the first clock edge that sees it released. Each result
// appears for exactly one cycle with o_done high, in the order of the items. The receiver
// cannot hold results off and must take each one in that cycle. The pipeline is made of
// a row of 34 square-root cells (one root bit each) and a row of 49 divider cells plus an
// overflow check (one quotient bit each), with six multiply and register stages around
// them. The gravity constant is written through i_cfg_we and i_cfg_data and is scaled by
// one hundredth inside; it should only be changed while no item is in flight.
module pair_gravity_force_unit import pgf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic                      i_cfg_we,
    input  wire logic [GC_W-1:0]           i_cfg_data,
    input  wire logic signed [POS_W-1:0]   i_a_pos_x,
    input  wire logic signed [POS_W-1:0]   i_a_pos_y,
    input  wire logic signed [POS_W-1:0]   i_b_pos_x,
    input  wire logic signed [POS_W-1:0]   i_b_pos_y,
    input  wire logic [MASS_W-1:0]         i_b_mass,
    input  wire logic [RAD_W-1:0]          i_a_radius,
    input  wire logic [RAD_W-1:0]          i_b_radius,
    output logic                           o_done,
    output logic signed [FORCE_W-1:0]      o_force_x,
    output logic signed [FORCE_W-1:0]      o_force_y,
    output logic                           o_collided,
    output logic                           o_coincident,
    output logic                           o_saturated
);

    // The numerator is G * mass * |delta| shifted up by two fraction widths.
    localparam int NUM_W    = PROD_W + 2 * FRAC_BITS;
    localparam int CW       = (NUM_W > DEN_W) ? NUM_W : DEN_W;
    localparam int POST_LAT = 3 + DIV_LAT;
    localparam int LAT      = 2 + SQRT_STEPS + POST_LAT + 1;

    // The 100 * d factor is split in two so that each denominator product stays small.
    localparam int D100_SPLIT = 21;
    localparam int DQ_W       = ROOT_W + D100_SPLIT;

    localparam logic [FORCE_W-1:0] F_POS = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] F_NEG = {1'b1, {(FORCE_W-1){1'b0}}};

    logic             accept;
    logic             r_busy;
    logic [GC_W-1:0]  r_gconst;
    logic [LAT-1:0]   r_vld;

    // Input stage: differences and their magnitudes.
    logic signed [DIFF_W-1:0] n_dx;
    logic signed [DIFF_W-1:0] n_dy;
    logic [DIFF_W-1:0] r0_adx;
    logic [DIFF_W-1:0] r0_ady;
    logic              r0_negx;
    logic              r0_negy;
    logic [MASS_W-1:0] r0_mass;
    logic [RSUM_W-1:0] r0_rsum;

    // Squares stage.
    logic [S_W-1:0]    r1_s;
    logic [RR_W-1:0]   r1_rr;
    logic [GM_W-1:0]   r1_gm;
    logic [DIFF_W-1:0] r1_adx;
    logic [DIFF_W-1:0] r1_ady;
    logic              r1_negx;
    logic              r1_negy;
    t_side1            n_side1;

    t_side1 r_sd1 [SQRT_STEPS];
    t_side2 r_sd2 [POST_LAT];
    t_side1 w_sd1;
    t_side2 w_sd2;

    logic [SQ_RW-1:0]   w_rem  [SQRT_STEPS+1];
    logic [ROOT_W-1:0]  w_root [SQRT_STEPS+1];
    logic [SQ_OP_W-1:0] w_op   [SQRT_STEPS+1];

    // Product stages after the root.
    logic [D2_W-1:0]    r_a_d2;
    logic [D100_W-1:0]  r_a_d100;
    logic [NP_W-1:0]    r_a_nxlo;
    logic [NP_W-1:0]    r_a_nxhi;
    logic [NP_W-1:0]    r_a_nylo;
    logic [NP_W-1:0]    r_a_nyhi;
    logic [DQ_W-1:0]    r_b_d00;
    logic [DQ_W-1:0]    r_b_d01;
    logic [DQ_W-1:0]    r_b_d10;
    logic [DQ_W-1:0]    r_b_d11;
    logic [CW-1:0]      r_b_numx;
    logic [CW-1:0]      r_b_numy;
    logic [DEN_W-1:0]   r_c_den;
    logic [CW-1:0]      r_c_numx;
    logic [CW-1:0]      r_c_numy;

    logic [QB-1:0] w_qx;
    logic [QB-1:0] w_qy;
    logic          w_ovfx;
    logic          w_ovfy;

    logic [FORCE_W:0] n_fx;
    logic [FORCE_W:0] n_fy;

    logic                      r_done;
    logic signed [FORCE_W-1:0] r_fx;
    logic signed [FORCE_W-1:0] r_fy;
    logic                      r_coll;
    logic                      r_coin;
    logic                      r_sat;

    // Clips a quotient to the signed range and applies the sign; the top bit is the
    // saturation flag.
    function automatic logic [FORCE_W:0] clip_force(input logic [QB-1:0] q,
                                                    input logic ovf, input logic neg);
        logic [QB-1:0]      lim;
        logic               sat;
        logic [FORCE_W-1:0] m;
        lim = neg ? QB'(F_NEG) : QB'(F_POS);
        sat = ovf || (q > lim);
        m   = sat ? lim[FORCE_W-1:0] : q[FORCE_W-1:0];
        return {sat, neg ? (FORCE_W'(0) - m) : m};
    endfunction

    assign accept = i_start && !r_busy;
    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_gconst <= GC_W'(1);
            r_vld    <= '0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                r_gconst <= i_cfg_data;
            end
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    assign n_dx = DIFF_W'(i_b_pos_x) - DIFF_W'(i_a_pos_x);
    assign n_dy = DIFF_W'(i_b_pos_y) - DIFF_W'(i_a_pos_y);

    always_ff @(posedge i_clk) begin
        r0_negx <= n_dx[DIFF_W-1];
        r0_negy <= n_dy[DIFF_W-1];
        r0_adx  <= n_dx[DIFF_W-1] ? (DIFF_W'(0) - n_dx) : n_dx;
        r0_ady  <= n_dy[DIFF_W-1] ? (DIFF_W'(0) - n_dy) : n_dy;
        r0_mass <= i_b_mass;
        r0_rsum <= RSUM_W'(i_a_radius) + RSUM_W'(i_b_radius);
    end

    always_ff @(posedge i_clk) begin
        r1_s    <= (S_W'(r0_adx) * S_W'(r0_adx)) + (S_W'(r0_ady) * S_W'(r0_ady));
        r1_rr   <= RR_W'(r0_rsum) * RR_W'(r0_rsum);
        r1_gm   <= GM_W'(r_gconst) * GM_W'(r0_mass);
        r1_adx  <= r0_adx;
        r1_ady  <= r0_ady;
        r1_negx <= r0_negx;
        r1_negy <= r0_negy;
    end

    // Collision is decided on the exact squared distance.
    always_comb begin
        n_side1.coin = (r1_adx == '0) && (r1_ady == '0);
        n_side1.negx = r1_negx;
        n_side1.negy = r1_negy;
        n_side1.coll = r1_s < S_W'(r1_rr);
        n_side1.adx  = r1_adx;
        n_side1.ady  = r1_ady;
        n_side1.gm   = r1_gm;
    end

    // Side data rides alongside the root cells.
    always_ff @(posedge i_clk) begin
        r_sd1[0] <= n_side1;
        for (int i = 1; i < SQRT_STEPS; i++) begin
            r_sd1[i] <= r_sd1[i-1];
        end
    end
    assign w_sd1 = r_sd1[SQRT_STEPS-1];

    // Row of square-root cells, one root bit per cell.
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_op[0]   = SQ_OP_W'(r1_s);

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        pgf_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rem  (w_rem[i]),
            .i_root (w_root[i]),
            .i_op   (w_op[i]),
            .o_rem  (w_rem[i+1]),
            .o_root (w_root[i+1]),
            .o_op   (w_op[i+1])
        );
    end

    // Denominator 100 * d^3 and numerators G * mass * |delta|, each multiply registered.
    always_ff @(posedge i_clk) begin
        r_a_d2   <= D2_W'(w_root[SQRT_STEPS]) * D2_W'(w_root[SQRT_STEPS]);
        r_a_d100 <= D100_W'(w_root[SQRT_STEPS]) * D100_W'(HUNDRED);
        r_a_nxlo <= NP_W'(w_sd1.gm[GM_SPLIT-1:0]) * NP_W'(w_sd1.adx);
        r_a_nxhi <= NP_W'(w_sd1.gm[GM_W-1:GM_SPLIT]) * NP_W'(w_sd1.adx);
        r_a_nylo <= NP_W'(w_sd1.gm[GM_SPLIT-1:0]) * NP_W'(w_sd1.ady);
        r_a_nyhi <= NP_W'(w_sd1.gm[GM_W-1:GM_SPLIT]) * NP_W'(w_sd1.ady);

        r_b_d00  <= DQ_W'(r_a_d2[ROOT_W-1:0]) * DQ_W'(r_a_d100[D100_SPLIT-1:0]);
        r_b_d01  <= DQ_W'(r_a_d2[ROOT_W-1:0]) * DQ_W'(r_a_d100[D100_W-1:D100_SPLIT]);
        r_b_d10  <= DQ_W'(r_a_d2[D2_W-1:ROOT_W]) * DQ_W'(r_a_d100[D100_SPLIT-1:0]);
        r_b_d11  <= DQ_W'(r_a_d2[D2_W-1:ROOT_W]) * DQ_W'(r_a_d100[D100_W-1:D100_SPLIT]);
        r_b_numx <= CW'((PROD_W'(r_a_nxhi) << GM_SPLIT) + PROD_W'(r_a_nxlo))
                    << (2 * FRAC_BITS);
        r_b_numy <= CW'((PROD_W'(r_a_nyhi) << GM_SPLIT) + PROD_W'(r_a_nylo))
                    << (2 * FRAC_BITS);

        r_c_den  <= DEN_W'((DSUM_W'(r_b_d11) << (ROOT_W + D100_SPLIT))
                           + (DSUM_W'(r_b_d10) << ROOT_W)
                           + (DSUM_W'(r_b_d01) << D100_SPLIT)
                           + DSUM_W'(r_b_d00));
        r_c_numx <= r_b_numx;
        r_c_numy <= r_b_numy;
    end

    always_ff @(posedge i_clk) begin
        r_sd2[0] <= '{coin: w_sd1.coin, negx: w_sd1.negx, negy: w_sd1.negy,
                      coll: w_sd1.coll};
        for (int i = 1; i < POST_LAT; i++) begin
            r_sd2[i] <= r_sd2[i-1];
        end
    end
    assign w_sd2 = r_sd2[POST_LAT-1];

    pgf_div #(.CW(CW)) u_div_x (
        .i_clk (i_clk),
        .i_num (r_c_numx),
        .i_den (r_c_den),
        .o_q   (w_qx),
        .o_ovf (w_ovfx)
    );

    pgf_div #(.CW(CW)) u_div_y (
        .i_clk (i_clk),
        .i_num (r_c_numy),
        .i_den (r_c_den),
        .o_q   (w_qy),
        .o_ovf (w_ovfy)
    );

    assign n_fx = clip_force(w_qx, w_ovfx, w_sd2.negx);
    assign n_fy = clip_force(w_qy, w_ovfy, w_sd2.negy);

    // Coincident positions give no direction, so the forces are forced to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[LAT-2];
        end
        r_coll <= w_sd2.coll;
        r_coin <= w_sd2.coin;
        if (w_sd2.coin) begin
            r_fx  <= '0;
            r_fy  <= '0;
            r_sat <= 1'b0;
        end else begin
            r_fx  <= n_fx[FORCE_W-1:0];
            r_fy  <= n_fy[FORCE_W-1:0];
            r_sat <= n_fx[FORCE_W] || n_fy[FORCE_W];
        end
    end

    assign o_done       = r_done;
    assign o_force_x    = r_fx;
    assign o_force_y    = r_fy;
    assign o_collided   = r_coll;
    assign o_coincident = r_coin;
    assign o_saturated  = r_sat;

    a_coin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_coincident |-> (o_force_x == '0) && (o_force_y == '0) && !o_saturated)
        else $error("coincident result carries a force");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_saturated |-> (o_force_x == F_POS) || (o_force_x == F_NEG)
                                  || (o_force_y == F_POS) || (o_force_y == F_NEG))
        else $error("saturated result has no clipped component");

    a_done_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    a_done_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_vld[LAT-2]) |-> o_done)
        else $error("accepted item lost in the pipeline");

endmodule
`default_nettype wire

>>> test/pair_gravity_force_unit_test.sv
`default_nettype none
// Self-checking bench for the pairwise gravity force unit. Items are driven at the
// falling clock edge, and each accepted item gets one expected result that is queued
// in order. Results are taken at the rising edge while o_done is high. Each one is
// compared with the oldest expected result, field by field.
module pair_gravity_force_unit_test;
    import pgf_pkg::*;

    localparam int FB         = FRAC_BITS_DEF;
    localparam int LATENCY    = 90;
    localparam int RAND_ITEMS = 700;
    localparam logic [FORCE_W-1:0] POS_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] NEG_MAX = {1'b1, {(FORCE_W-1){1'b0}}};

    // One pair of bodies, as it goes onto the input ports.
    typedef struct {
        logic signed [POS_W-1:0] ax, ay, bx, by;
        logic [MASS_W-1:0]       mass;
        logic [RAD_W-1:0]        ra, rb;
    } pair_t;

    // One force result, as it comes off the output ports.
    typedef struct {
        logic signed [FORCE_W-1:0] fx, fy;
        logic                      coll, coin, sat;
    } force_t;

    // A directed row. Where known is set, the expected result is typed into the row.
    typedef struct {
        pair_t  p;
        logic   known;
        force_t res;
    } row_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_start = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [GC_W-1:0]         i_cfg_data = '0;
    logic signed [POS_W-1:0] i_a_pos_x = '0, i_a_pos_y = '0, i_b_pos_x = '0, i_b_pos_y = '0;
    logic [MASS_W-1:0]       i_b_mass = '0;
    logic [RAD_W-1:0]        i_a_radius = '0, i_b_radius = '0;
    logic                    o_busy, o_done, o_collided, o_coincident, o_saturated;
    logic signed [FORCE_W-1:0] o_force_x, o_force_y;

    pair_gravity_force_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_a_pos_x(i_a_pos_x), .i_a_pos_y(i_a_pos_y),
        .i_b_pos_x(i_b_pos_x), .i_b_pos_y(i_b_pos_y),
        .i_b_mass(i_b_mass), .i_a_radius(i_a_radius), .i_b_radius(i_b_radius),
        .o_done(o_done), .o_force_x(o_force_x), .o_force_y(o_force_y),
        .o_collided(o_collided), .o_coincident(o_coincident), .o_saturated(o_saturated)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The testbench copy of the gravity constant, kept in step with every write.
    logic [GC_W-1:0] grav_const = 16'd1;

    force_t pending_forces[$];
    int     items_sent = 0;
    int     results_seen = 0;
    int     mismatches = 0;
    int     saturated_seen = 0;
    int     collided_seen = 0;
    int     coincident_seen = 0;
    int     phases_run = 0;

    // Divides one clipped component out of the shared denominator. The magnitude is
    // limited to the 48-bit range, one step further on the negative side.
    function automatic logic [FORCE_W-1:0] clip_component(
        input logic [127:0] gm, input logic [DIFF_W-1:0] mag, input logic neg,
        input logic [127:0] den, inout logic sat
    );
        logic [127:0] q, lim;
        begin
            q   = ((gm * 128'(mag)) << (2 * FB)) / den;
            lim = neg ? 128'(NEG_MAX) : 128'(POS_MAX);
            if (q > lim) begin
                q   = lim;
                sat = 1'b1;
            end
            clip_component = neg ? -q[FORCE_W-1:0] : q[FORCE_W-1:0];
        end
    endfunction

    // Pull of body B on body A under the current gravity constant.
    function automatic force_t pull_of_b(input pair_t p, input logic [GC_W-1:0] g);
        logic signed [DIFF_W-1:0] dx, dy;
        logic [DIFF_W-1:0]        adx, ady;
        logic [RSUM_W-1:0]        rsum;
        logic [127:0]             s, rr, d, c, den, gm;
        force_t                   r;
        begin
            dx   = {p.bx[POS_W-1], p.bx} - {p.ax[POS_W-1], p.ax};
            dy   = {p.by[POS_W-1], p.by} - {p.ay[POS_W-1], p.ay};
            adx  = dx[DIFF_W-1] ? -dx : dx;
            ady  = dy[DIFF_W-1] ? -dy : dy;
            rsum = {1'b0, p.ra} + {1'b0, p.rb};
            s    = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
            rr   = 128'(rsum) * 128'(rsum);
            r    = '{fx: '0, fy: '0, coll: (s < rr), coin: 1'b0, sat: 1'b0};
            if (s == 0) begin
                r.coin = 1'b1;
            end else begin
                // Integer square root, one bit at a time from the top.
                d = '0;
                for (int b = ROOT_W - 1; b >= 0; b--) begin
                    c = d | (128'd1 << b);
                    if (c * c <= s) d = c;
                end
                den  = d * d * d * 128'd100;
                gm   = 128'(g) * 128'(p.mass);
                r.fx = clip_component(gm, adx, dx[DIFF_W-1], den, r.sat);
                r.fy = clip_component(gm, ady, dy[DIFF_W-1], den, r.sat);
            end
            pull_of_b = r;
        end
    endfunction

    // Puts one item on the ports at a falling edge; the next rising edge takes it.
    // The start line is left high, so back-to-back items need no extra edge.
    task automatic send_pair(input pair_t p, input logic known, input force_t res);
        begin
            @(negedge i_clk);
            while (o_busy) begin
                i_start = 1'b0;
                @(negedge i_clk);
            end
            i_start    = 1'b1;
            i_a_pos_x  = p.ax;
            i_a_pos_y  = p.ay;
            i_b_pos_x  = p.bx;
            i_b_pos_y  = p.by;
            i_b_mass   = p.mass;
            i_a_radius = p.ra;
            i_b_radius = p.rb;
            pending_forces.push_back(known ? res : pull_of_b(p, grav_const));
            items_sent++;
        end
    endtask

    // Leaves the sender quiet, with the start line low; n says for how long.
    task automatic hold_off(input int n);
        begin
            repeat (n) begin
                @(negedge i_clk);
                i_start = 1'b0;
            end
        end
    endtask

    // A random gap: mostly none, sometimes short, rarely a long stretch.
    task automatic random_gap;
        int pick;
        begin
            pick = $urandom_range(99);
            if (pick < 30) hold_off($urandom_range(3, 1));
            else if (pick < 36) hold_off($urandom_range(60, 8));
        end
    endtask

    // Waits until every queued result has come back and the pipeline has emptied.
    task automatic drain;
        begin
            hold_off(1);
            while (pending_forces.size() != 0) @(negedge i_clk);
            hold_off(LATENCY + 10);
        end
    endtask

    // Writes the gravity constant. The block is idle at this point.
    task automatic set_gravity(input logic [GC_W-1:0] g);
        begin
            @(negedge i_clk);
            i_cfg_we   = 1'b1;
            i_cfg_data = g;
            @(negedge i_clk);
            i_cfg_we   = 1'b0;
            grav_const = g;
            phases_run++;
        end
    endtask

    // Random pair. Most pairs are close with moderate masses so the forces land in
    // range; the rest use full-width fields, coincident positions or range ends.
    function automatic pair_t random_pair;
        pair_t p;
        int    kind;
        begin
            kind   = $urandom_range(99);
            p.ax   = $urandom;
            p.ay   = $urandom;
            p.mass = $urandom;
            p.ra   = RAD_W'($urandom);
            p.rb   = RAD_W'($urandom);
            if (kind < 55) begin
                p.bx   = p.ax + $signed($urandom_range(1 << 22)) - (1 << 21);
                p.by   = p.ay + $signed($urandom_range(1 << 22)) - (1 << 21);
                p.mass = $urandom_range(1 << 24);
                p.ra   = RAD_W'($urandom_range(1 << 21));
                p.rb   = RAD_W'($urandom_range(1 << 21));
            end else if (kind < 85) begin
                p.bx = $urandom;
                p.by = $urandom;
            end else if (kind < 92) begin
                p.bx = p.ax;
                p.by = p.ay;
                if ($urandom_range(1)) begin
                    p.ra = '0;
                    p.rb = '0;
                end
            end else begin
                p.ax = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
                p.bx = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
                p.by = p.ay + $signed($urandom_range(15)) - 8;
            end
            random_pair = p;
        end
    endfunction

    // Result checking. Outputs are read at the rising edge that ends the strobe cycle.
    always @(posedge i_clk) begin
        force_t want;
        if (i_rst_n && o_done) begin
            results_seen++;
            saturated_seen  += int'(o_saturated);
            collided_seen   += int'(o_collided);
            coincident_seen += int'(o_coincident);
            if (pending_forces.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no item waiting: fx=%0d fy=%0d",
                             o_force_x, o_force_y);
            end else begin
                want = pending_forces.pop_front();
                if (o_force_x !== want.fx || o_force_y !== want.fy ||
                    o_collided !== want.coll || o_coincident !== want.coin ||
                    o_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: want fx=%0d fy=%0d c=%b q=%b s=%b, got fx=%0d fy=%0d c=%b q=%b s=%b",
                                 results_seen, want.fx, want.fy, want.coll, want.coin,
                                 want.sat, o_force_x, o_force_y, o_collided,
                                 o_coincident, o_saturated);
                end
            end
        end
    end

    // Timeout guard: far beyond the slowest correct run.
    initial begin
        #(12 * 1_000_000);
        $display("pair_gravity_force_unit_test: errors");
        $finish;
    end

    row_t   rows[14];
    force_t none_known;

    initial begin
        pair_t p;
        none_known = '{fx: '0, fy: '0, coll: 1'b0, coin: 1'b0, sat: 1'b0};

        // Directed rows, run under the constant left by reset. Unit raw distances with
        // the largest mass clip in every direction; rows past 6 go to the predictor.
        rows[0]  = '{'{0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 1'b0, 1'b1, 1'b0}};
        rows[1]  = '{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                       '1, '1, '1}, 1'b1, '{0, 0, 1'b1, 1'b1, 1'b0}};
        rows[2]  = '{'{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                       0, 0, 0}, 1'b1, '{0, 0, 1'b0, 1'b0, 1'b0}};
        rows[3]  = '{'{0, 0, 1, 0, '1, 0, 0}, 1'b1, '{POS_MAX, 0, 1'b0, 1'b0, 1'b1}};
        rows[4]  = '{'{0, 0, -1, 0, '1, 0, 0}, 1'b1, '{NEG_MAX, 0, 1'b0, 1'b0, 1'b1}};
        rows[5]  = '{'{0, 0, 0, 1, '1, 0, 0}, 1'b1, '{0, POS_MAX, 1'b0, 1'b0, 1'b1}};
        rows[6]  = '{'{0, 0, 0, -1, '1, 0, 0}, 1'b1, '{0, NEG_MAX, 1'b0, 1'b0, 1'b1}};
        rows[7]  = '{'{0, 0, 4096, 0, 4096, 0, 0}, 1'b0, none_known};
        rows[8]  = '{'{0, 0, 4096, 4096, 32'h00100000, 2048, 2048}, 1'b0, none_known};
        rows[9]  = '{'{0, 0, 3 * 4096, 4 * 4096, 32'h01000000, 2 * 4096, 3 * 4096},
                     1'b0, none_known};
        rows[10] = '{'{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                       '1, '1, '1}, 1'b0, none_known};
        rows[11] = '{'{32'sh7FFFFFFF, 0, 32'sh80000000, 0, '1, 0, 0}, 1'b0, none_known};
        rows[12] = '{'{100, -200, -300, 400, 32'h00ABCDEF, 500, 10}, 1'b0, none_known};
        rows[13] = '{'{0, 0, 16, 0, 32'h7FFFFFFF, 8, 8}, 1'b0, none_known};

        // Reset is applied once, with every input at rest.
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < 14; k++) begin
            send_pair(rows[k].p, rows[k].known, rows[k].res);
            random_gap();
        end
        drain();

        // Random phases through several constants, the extremes among them. Each
        // phase ends with the sender waiting until every result has come back.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_gravity(16'd0);
                1: set_gravity(16'hFFFF);
                2: set_gravity(16'd100);
                3: set_gravity(16'd1);
                default: set_gravity(16'($urandom));
            endcase
            for (int k = 0; k < RAND_ITEMS / 7; k++) begin
                p = random_pair();
                send_pair(p, 1'b0, none_known);
                // Some stretches run back to back with no gaps at all.
                if (ph != 4) random_gap();
            end
            drain();
        end

        $display("covered %0d items over %0d gravity settings: %0d clipped, %0d collided, %0d coincident",
                 items_sent, phases_run, saturated_seen, collided_seen, coincident_seen);
        if (mismatches == 0 && pending_forces.size() == 0) begin
            $display("pair_gravity_force_unit_test: clean");
        end else begin
            $display("%0d mismatches, %0d results never came", mismatches,
                     pending_forces.size());
            $display("pair_gravity_force_unit_test: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
design/pgf_pkg.sv
design/pgf_sqrt_cell.sv
design/pgf_div_cell.sv
design/pgf_div.sv
design/pair_gravity_force_unit.sv
test/pair_gravity_force_unit_test.sv
